FILE: hdl/dft_pkg.sv
// Shared types and codes for the depth-first traversal unit.
package dft_pkg;

    localparam int COUNT_W  = 7;
    localparam int VERTEX_W = 6;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] RES_FINISHED = 2'd0;
    localparam logic [STATUS_W-1:0] RES_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] RES_REJECTED = 2'd2;
    localparam logic [STATUS_W-1:0] RES_CLEARED  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_CLEAR,
        S_ROOT,
        S_ROOT_HEAD,
        S_STEP,
        S_POP,
        S_EDGE,
        S_PUSH
    } state_t;

    // Address source for the list head memory read port
    typedef enum logic [1:0] {
        HSEL_INPUT,
        HSEL_ROOT,
        HSEL_TARGET
    } head_sel_t;

    typedef struct packed {
        head_sel_t head_sel;
        logic      capture;
        logic      add_commit;
        logic      emit_reject;
        logic      emit_accept;
        logic      clear_graph;
        logic      run_init;
        logic      root_inc;
        logic      mark_root;
        logic      load_root;
        logic      finish_top;
        logic      pop_load;
        logic      edge_adv;
        logic      push;
        logic      push_load;
        logic      flush;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic root_done;
        logic root_visited;
        logic top_null;
        logic depth_one;
        logic push_ok;
    } stat_t;

endpackage

FILE: hdl/depth_first_traversal_unit.sv
// Top level of the depth-first traversal unit (post-order vertex reports).
//
//  channel   direction  handshake                         payload
//  -------   ---------  --------------------------------  -------------------------------
//  item      in         start && !busy                    kind, source_vertex,
//                                                         target_vertex
//  result    out        result_valid, one cycle, no stall status, finished_vertex, last
//  config    in         cfg_we, no wait                   cfg_data (vertex_count)
//
//  Add edge and clear pass through one state (S_ADD or S_CLEAR) before the unit is idle again.
//  During a run, every stack step waits on a registered read of one of the
//  memories (list heads, edge store or walk stack).
//  Reset is asynchronous, active low; it empties the graph and sets vertex_count to 64.
//  No clearing pass: head entries carry valid bits, cleared at once by reset or clear.
//  Results leave on a one-cycle strobe; the receiver cannot stall them.
module depth_first_traversal_unit
    import dft_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [VERTEX_W-1:0] source_vertex,
    input  logic [VERTEX_W-1:0] target_vertex,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [VERTEX_W-1:0] finished_vertex,
    output logic                last
);

    cmd_t  cmd;
    stat_t stat;

    // Controller walks the states; it sees only the status flags of the datapath
    dft_controller u_controller
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Datapath owns the graph store, visit bits, stack and result register
    dft_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .source_vertex   (source_vertex),
        .target_vertex   (target_vertex),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .result_valid    (result_valid),
        .status          (status),
        .finished_vertex (finished_vertex),
        .last            (last)
    );

endmodule

FILE: hdl/dft_datapath.sv
// Datapath: graph memories, visit bits, walk stack and result register.
module dft_datapath
    import dft_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [VERTEX_W-1:0] source_vertex,
    input  logic [VERTEX_W-1:0] target_vertex,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic                result_valid,
    output logic [STATUS_W-1:0] status,
    output logic [VERTEX_W-1:0] finished_vertex,
    output logic                last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = $clog2(MAX_EDGES);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int DW = VW + 1;
    localparam logic [EW-1:0]      NULL_EDGE = EW'(MAX_EDGES);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

    logic [COUNT_W-1:0]  vcount_reg;
    logic [COUNT_W-1:0]  n_eff;
    logic [VERTEX_W-1:0] src_reg;
    logic [VERTEX_W-1:0] dst_reg;

    logic [EW-1:0]           head_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] head_valid_reg;
    logic [EW-1:0]           head_rd_reg;
    logic                    head_vld_rd_reg;
    logic [VW-1:0]           head_addr;
    logic [EW-1:0]           head_q;

    logic [VW+EW-1:0] edge_mem [MAX_EDGES];
    logic [VW+EW-1:0] edge_rd_reg;
    logic [EW-1:0]    edges_used_reg;
    logic [VW-1:0]    edge_t;
    logic [EW-1:0]    edge_nxt;

    logic [MAX_VERTICES-1:0] visited_reg;

    logic [VW+EW-1:0] stack_mem [MAX_VERTICES];
    logic [VW+EW-1:0] stack_rd_reg;
    logic [VW-1:0]    stack_rd_addr;
    logic [VW-1:0]    stack_wr_addr;
    logic [DW-1:0]    depth_reg;
    logic [DW-1:0]    root_reg;

    logic [VW-1:0] top_v_reg;
    logic [EW-1:0] top_e_reg;
    logic [VW-1:0] t_reg;
    logic [VW-1:0] pend_v_reg;
    logic          pend_valid_reg;

    logic                result_valid_reg, result_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VERTEX_W-1:0] fv_reg, fv_next;
    logic                last_reg, last_next;

    assign n_eff    = (vcount_reg > MAX_COUNT) ? MAX_COUNT : vcount_reg;
    assign head_q   = head_vld_rd_reg ? head_rd_reg : NULL_EDGE;
    assign edge_t   = edge_rd_reg[VW+EW-1:EW];
    assign edge_nxt = edge_rd_reg[EW-1:0];

    assign stack_rd_addr = VW'(depth_reg - DW'(2));
    assign stack_wr_addr = VW'(depth_reg - DW'(1));

    always_comb
    begin
        case (cmd.head_sel)
            HSEL_INPUT:  head_addr = source_vertex[VW-1:0];
            HSEL_ROOT:   head_addr = root_reg[VW-1:0];
            HSEL_TARGET: head_addr = edge_t;
            default:     head_addr = source_vertex[VW-1:0];
        endcase
    end

    // Status back to the controller
    always_comb
    begin
        stat.reject       = (edges_used_reg == NULL_EDGE)
                            || (COUNT_W'(src_reg) >= n_eff)
                            || (COUNT_W'(dst_reg) >= n_eff);
        stat.root_done    = (COUNT_W'(root_reg) == n_eff);
        stat.root_visited = visited_reg[root_reg[VW-1:0]];
        stat.top_null     = (top_e_reg == NULL_EDGE);
        stat.depth_one    = (depth_reg == DW'(1));
        stat.push_ok      = (COUNT_W'(edge_t) < n_eff) && !visited_reg[edge_t];
    end

    // Memories
    always_ff @(posedge clk)
    begin
        head_rd_reg     <= head_mem[head_addr];
        head_vld_rd_reg <= head_valid_reg[head_addr];
        if (cmd.add_commit)
        begin
            head_mem[src_reg[VW-1:0]] <= edges_used_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_rd_reg <= edge_mem[top_e_reg[AW-1:0]];
        if (cmd.add_commit)
        begin
            edge_mem[edges_used_reg[AW-1:0]] <= {dst_reg[VW-1:0], head_q};
        end
    end

    always_ff @(posedge clk)
    begin
        stack_rd_reg <= stack_mem[stack_rd_addr];
        if (cmd.push)
        begin
            stack_mem[stack_wr_addr] <= {top_v_reg, edge_nxt};
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            src_reg <= source_vertex;
            dst_reg <= target_vertex;
        end
        if (cmd.load_root)
        begin
            top_v_reg <= root_reg[VW-1:0];
            top_e_reg <= head_q;
        end
        else if (cmd.pop_load)
        begin
            {top_v_reg, top_e_reg} <= stack_rd_reg;
        end
        else if (cmd.push_load)
        begin
            top_v_reg <= t_reg;
            top_e_reg <= head_q;
        end
        else if (cmd.edge_adv)
        begin
            top_e_reg <= edge_nxt;
        end
        if (cmd.push)
        begin
            t_reg <= edge_t;
        end
        if (cmd.finish_top)
        begin
            pend_v_reg <= top_v_reg;
        end
        status_reg <= status_next;
        fv_reg     <= fv_next;
        last_reg   <= last_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg       <= COUNT_RESET;
            head_valid_reg   <= '0;
            edges_used_reg   <= '0;
            visited_reg      <= '0;
            depth_reg        <= '0;
            root_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            if (cmd.clear_graph)
            begin
                head_valid_reg <= '0;
                edges_used_reg <= '0;
            end
            else if (cmd.add_commit)
            begin
                head_valid_reg[src_reg[VW-1:0]] <= 1'b1;
                edges_used_reg <= edges_used_reg + EW'(1);
            end
            if (cmd.run_init)
            begin
                visited_reg    <= '0;
                depth_reg      <= '0;
                root_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.mark_root)
                begin
                    visited_reg[root_reg[VW-1:0]] <= 1'b1;
                end
                if (cmd.push)
                begin
                    visited_reg[edge_t] <= 1'b1;
                end
                if (cmd.root_inc)
                begin
                    root_reg <= root_reg + DW'(1);
                end
                if (cmd.load_root)
                begin
                    depth_reg <= DW'(1);
                end
                else if (cmd.finish_top)
                begin
                    depth_reg <= depth_reg - DW'(1);
                end
                else if (cmd.push_load)
                begin
                    depth_reg <= depth_reg + DW'(1);
                end
                if (cmd.finish_top)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Finished vertices are held back one report so the final one can carry last
    always_comb
    begin
        result_valid_next = 1'b0;
        status_next       = status_reg;
        fv_next           = fv_reg;
        last_next         = last_reg;
        if (cmd.emit_reject)
        begin
            result_valid_next = 1'b1;
            status_next       = RES_REJECTED;
            fv_next           = '0;
            last_next         = 1'b1;
        end
        else if (cmd.emit_accept)
        begin
            result_valid_next = 1'b1;
            status_next       = RES_ACCEPTED;
            fv_next           = '0;
            last_next         = 1'b1;
        end
        else if (cmd.clear_graph)
        begin
            result_valid_next = 1'b1;
            status_next       = RES_CLEARED;
            fv_next           = '0;
            last_next         = 1'b1;
        end
        else if ((cmd.finish_top || cmd.flush) && pend_valid_reg)
        begin
            result_valid_next = 1'b1;
            status_next       = RES_FINISHED;
            fv_next           = VERTEX_W'(pend_v_reg);
            last_next         = cmd.flush;
        end
    end

    assign result_valid    = result_valid_reg;
    assign status          = status_reg;
    assign finished_vertex = fv_reg;
    assign last            = last_reg;

endmodule

FILE: hdl/dft_controller.sv
// Controller: sequences edge loading, clearing and the stack-based walk.
module dft_controller
    import dft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  stat_t             stat,
    output cmd_t              cmd,
    output logic              busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.head_sel = HSEL_INPUT;
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (kind)
                        KIND_ADD:   state_next = S_ADD;
                        KIND_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            state_next   = S_ROOT;
                        end
                        KIND_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                if (stat.reject)
                begin
                    cmd.emit_reject = 1'b1;
                end
                else
                begin
                    cmd.add_commit  = 1'b1;
                    cmd.emit_accept = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clear_graph = 1'b1;
                state_next      = S_IDLE;
            end
            S_ROOT:
            begin
                cmd.head_sel = HSEL_ROOT;
                if (stat.root_done)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.root_visited)
                begin
                    cmd.root_inc = 1'b1;
                end
                else
                begin
                    cmd.mark_root = 1'b1;
                    state_next    = S_ROOT_HEAD;
                end
            end
            S_ROOT_HEAD:
            begin
                cmd.load_root = 1'b1;
                cmd.root_inc  = 1'b1;
                state_next    = S_STEP;
            end
            S_STEP:
            begin
                if (stat.top_null)
                begin
                    cmd.finish_top = 1'b1;
                    state_next     = stat.depth_one ? S_ROOT : S_POP;
                end
                else
                begin
                    state_next = S_EDGE;
                end
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_STEP;
            end
            S_EDGE:
            begin
                cmd.head_sel = HSEL_TARGET;
                cmd.edge_adv = 1'b1;
                if (stat.push_ok)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_PUSH:
            begin
                cmd.push_load = 1'b1;
                state_next    = S_STEP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: hdl/dft_checker.sv
// Port-level checker for the depth-first traversal unit, with its bind.
module dft_checker
    import dft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic                result_valid,
    input  logic [STATUS_W-1:0] status,
    input  logic [VERTEX_W-1:0] finished_vertex,
    input  logic                last
);

    // A transfer of a defined kind puts the unit to work: busy is high in the cycle after it
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (kind == KIND_ADD || kind == KIND_RUN || kind == KIND_CLEAR)
        |=> busy)
        else $error("busy not raised after transfer");

    // Edge and clear responses are single results
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != RES_FINISHED) |-> last && (finished_vertex == '0))
        else $error("non-vertex result without last or with vertex");

    // No result directly follows the last result
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result right after last");

    // An idle unit produces no result in the next cycle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid)
        else $error("result without work in progress");

endmodule

bind depth_first_traversal_unit dft_checker u_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .result_valid    (result_valid),
    .status          (status),
    .finished_vertex (finished_vertex),
    .last            (last)
);
